### sv/resp_request_framer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the request framer
// Shared concurrent assertion forms, clocked on i_clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef RESP_REQUEST_FRAMER_TOP_MACROS_SVH
`define RESP_REQUEST_FRAMER_TOP_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define RRF_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("framer assertion failed");

// A condition that must hold in the same cycle as a trigger.
`define RRF_ASSERT_IMPLY(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("framer assertion failed");

// A condition that must hold in the cycle after a trigger.
`define RRF_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("framer assertion failed");

`endif

### sv/rrf_pkg.sv
// ----------------------------------------------------------------------------
// Request framer package
// Types, character codes and status codes shared by the framer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rrf_pkg;

    localparam int RRF_LEN_BITS    = 32;
    localparam int RRF_QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        ST_ARRAY_DONE  = 3'd0,
        ST_INLINE_DONE = 3'd1,
        ST_BAD_COUNT   = 3'd2,
        ST_NO_DOLLAR   = 3'd3,
        ST_BAD_LENGTH  = 3'd4,
        ST_BAD_TERM    = 3'd5
    } t_status;

    // One received byte with its decode.
    typedef struct packed {
        logic [7:0] data;
        logic       is_star;
        logic       is_dollar;
        logic       is_cr;
        logic       is_lf;
        logic       is_digit;
        logic [3:0] digit;
    } t_byte_class;

    typedef struct packed {
        t_status     status;
        logic [31:0] request_length;
        logic [31:0] arg_count;
    } t_result;

endpackage

`default_nettype wire

### sv/resp_request_framer_top.sv
// Request framer: one received byte per word, one result word per request.
// Throughput: one byte per cycle while the result queue is not full; the parser updates its state per byte.
// Empty drops once the result queue registers the word pushed as the parser takes a request's last byte.
// Input and result queues are two words deep, so each side may stall alone.
// Reset: synchronous, active low; clears the parse state and both queues.
// ----------------------------------------------------------------------------
// Request framer top level
// Classifier and input queue in front, parser and result queue behind.
// ----------------------------------------------------------------------------
`default_nettype none

module resp_request_framer_top #(
    parameter int LEN_BITS    = rrf_pkg::RRF_LEN_BITS,
    parameter int QUEUE_DEPTH = rrf_pkg::RRF_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        pop,
    output logic             empty,
    output logic [2:0]       o_status,
    output logic [31:0]      o_request_length,
    output logic [31:0]      o_arg_count
);

    rrf_pkg::t_byte_class in_class, q_class;
    rrf_pkg::t_result     res, q_res;
    logic                 q_empty, take, res_full, res_push;

    rrf_classify u_classify (
        .i_data  (i_data_byte),
        .o_class (in_class)
    );

    rrf_fifo #(
        .WIDTH ($bits(rrf_pkg::t_byte_class)),
        .DEPTH (QUEUE_DEPTH)
    ) u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (in_class),
        .o_full  (full),
        .i_pop   (take),
        .o_data  (q_class),
        .o_empty (q_empty)
    );

    rrf_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_class    (q_class),
        .i_valid    (!q_empty),
        .o_take     (take),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_result   (res)
    );

    rrf_fifo #(
        .WIDTH ($bits(rrf_pkg::t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (q_res),
        .o_empty (empty)
    );

    assign o_status         = q_res.status;
    assign o_request_length = q_res.request_length;
    assign o_arg_count      = q_res.arg_count;

endmodule

`default_nettype wire

### sv/rrf_fifo.sv
// ----------------------------------------------------------------------------
// Small word queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module rrf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rrf_pkg::RRF_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### sv/rrf_classify.sv
// ----------------------------------------------------------------------------
// Byte classifier
// Decodes each received byte into the framing characters and a digit value.
// ----------------------------------------------------------------------------
`default_nettype none

module rrf_classify (
    input  wire logic [7:0]     i_data,
    output rrf_pkg::t_byte_class o_class
);

    logic [7:0] offset;

    assign offset = i_data - rrf_pkg::CH_ZERO;

    always_comb begin
        o_class.data      = i_data;
        o_class.is_star   = (i_data == rrf_pkg::CH_STAR);
        o_class.is_dollar = (i_data == rrf_pkg::CH_DOLLAR);
        o_class.is_cr     = (i_data == rrf_pkg::CH_CR);
        o_class.is_lf     = (i_data == rrf_pkg::CH_LF);
        o_class.is_digit  = (i_data >= rrf_pkg::CH_ZERO) && (i_data <= rrf_pkg::CH_NINE);
        o_class.digit     = offset[3:0];
    end

endmodule

`default_nettype wire

### sv/rrf_parser.sv
// ----------------------------------------------------------------------------
// Request parser
// Walks the framing state one classified word at a time and emits results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "resp_request_framer_top_macros.svh"

module rrf_parser #(
    parameter int LEN_BITS = rrf_pkg::RRF_LEN_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rrf_pkg::t_byte_class i_class,
    input  wire logic                 i_valid,
    output logic                      o_take,
    input  wire logic                 i_res_full,
    output logic                      o_res_push,
    output rrf_pkg::t_result          o_result
);

    localparam int PW = LEN_BITS + 4;

    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_INLINE  = 9'b000000010,
        PH_COUNT   = 9'b000000100,
        PH_ARG     = 9'b000001000,
        PH_LEN     = 9'b000010000,
        PH_PAYLOAD = 9'b000100000,
        PH_TERM1   = 9'b001000000,
        PH_TERM2   = 9'b010000000,
        PH_DISCARD = 9'b100000000
    } t_phase;

    t_phase              r_phase, n_phase;
    logic                r_acr, n_acr;
    logic                r_inv, n_inv;
    logic                r_ds, n_ds;
    logic [LEN_BITS-1:0] r_acc, n_acc;
    logic [LEN_BITS-1:0] r_args_left, n_args_left;
    logic [LEN_BITS-1:0] r_args_total, n_args_total;
    logic [LEN_BITS-1:0] r_pay_left, n_pay_left;
    logic [31:0]         r_rb, n_rb;
    logic [7:0]          r_held, n_held;

    logic [PW-1:0]       prod;
    logic                ovf;
    logic [31:0]         rb_inc;
    logic [63:0]         total_ext;
    logic [31:0]         total_sat;
    logic                lf_after_cr;
    logic [LEN_BITS-1:0] args_dec;
    logic [LEN_BITS-1:0] pay_dec;

    assign o_take      = i_valid && !i_res_full;
    assign prod        = (PW'(r_acc) << 3) + (PW'(r_acc) << 1) + PW'(i_class.digit);
    assign ovf         = |prod[PW-1:LEN_BITS];
    assign rb_inc      = (r_rb == 32'hFFFF_FFFF) ? r_rb : r_rb + 32'd1;
    assign total_ext   = 64'(r_args_total);
    assign total_sat   = (|total_ext[63:32]) ? 32'hFFFF_FFFF : total_ext[31:0];
    assign lf_after_cr = r_acr && i_class.is_lf;
    assign args_dec    = (r_args_left != '0) ? r_args_left - 1'b1 : r_args_left;
    assign pay_dec     = (r_pay_left != '0) ? r_pay_left - 1'b1 : r_pay_left;

    always_comb begin
        n_phase      = r_phase;
        n_acr        = r_acr;
        n_inv        = r_inv;
        n_ds         = r_ds;
        n_acc        = r_acc;
        n_args_left  = r_args_left;
        n_args_total = r_args_total;
        n_pay_left   = r_pay_left;
        n_rb         = r_rb;
        n_held       = r_held;
        o_res_push   = 1'b0;
        o_result.status         = rrf_pkg::ST_ARRAY_DONE;
        o_result.request_length = '0;
        o_result.arg_count      = '0;

        if (o_take) begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_rb  = 32'd1;
                    n_inv = 1'b0;
                    n_ds  = 1'b0;
                    n_acc = '0;
                    n_acr = !i_class.is_star && i_class.is_cr;
                    n_phase = i_class.is_star ? PH_COUNT : PH_INLINE;
                end
                PH_INLINE: begin
                    n_rb = rb_inc;
                    if (lf_after_cr) begin
                        n_acr      = 1'b0;
                        n_phase    = PH_IDLE;
                        o_res_push = 1'b1;
                        o_result.status         = rrf_pkg::ST_INLINE_DONE;
                        o_result.request_length = rb_inc;
                    end else begin
                        n_acr = i_class.is_cr;
                    end
                end
                PH_COUNT, PH_LEN: begin
                    n_rb = rb_inc;
                    if (lf_after_cr) begin
                        n_acr = 1'b0;
                        if (!r_ds || r_inv) begin
                            n_phase    = PH_IDLE;
                            o_res_push = 1'b1;
                            o_result.status = (r_phase == PH_COUNT) ?
                                rrf_pkg::ST_BAD_COUNT : rrf_pkg::ST_BAD_LENGTH;
                        end else if (r_phase == PH_COUNT) begin
                            if (r_acc == '0) begin
                                n_phase    = PH_IDLE;
                                o_res_push = 1'b1;
                                o_result.request_length = rb_inc;
                            end else begin
                                n_args_left  = r_acc;
                                n_args_total = r_acc;
                                n_phase      = PH_ARG;
                            end
                        end else begin
                            n_pay_left = r_acc;
                            n_phase    = (r_acc != '0) ? PH_PAYLOAD : PH_TERM1;
                        end
                    end else begin
                        // A CR that is not followed by LF spoils the number.
                        n_inv = r_inv || r_acr;
                        n_acr = i_class.is_cr;
                        if (!i_class.is_cr) begin
                            if (!i_class.is_digit || ovf) begin
                                n_inv = 1'b1;
                            end else begin
                                n_acc = prod[LEN_BITS-1:0];
                                n_ds  = 1'b1;
                            end
                        end
                    end
                end
                PH_ARG: begin
                    n_rb  = rb_inc;
                    n_inv = 1'b0;
                    n_ds  = 1'b0;
                    n_acc = '0;
                    if (i_class.is_dollar) begin
                        n_acr   = 1'b0;
                        n_phase = PH_LEN;
                    end else begin
                        n_acr      = i_class.is_cr;
                        n_phase    = PH_DISCARD;
                        o_res_push = 1'b1;
                        o_result.status = rrf_pkg::ST_NO_DOLLAR;
                    end
                end
                PH_PAYLOAD: begin
                    n_rb       = rb_inc;
                    n_pay_left = pay_dec;
                    if (pay_dec == '0) begin
                        n_phase = PH_TERM1;
                    end
                end
                PH_TERM1: begin
                    n_rb    = rb_inc;
                    n_held  = i_class.data;
                    n_phase = PH_TERM2;
                end
                PH_TERM2: begin
                    if (r_held == rrf_pkg::CH_CR && i_class.is_lf) begin
                        n_rb        = rb_inc;
                        n_args_left = args_dec;
                        if (args_dec == '0) begin
                            n_phase    = PH_IDLE;
                            o_res_push = 1'b1;
                            o_result.request_length = rb_inc;
                            o_result.arg_count      = total_sat;
                        end else begin
                            n_phase = PH_ARG;
                        end
                    end else begin
                        // Both checked bytes start a new request; the held
                        // byte opens it and this word is its second byte.
                        o_res_push = 1'b1;
                        o_result.status = rrf_pkg::ST_BAD_TERM;
                        n_rb  = 32'd2;
                        n_inv = 1'b0;
                        n_ds  = 1'b0;
                        n_acc = '0;
                        n_acr = i_class.is_cr;
                        if (r_held == rrf_pkg::CH_STAR) begin
                            n_phase = PH_COUNT;
                            if (!i_class.is_cr) begin
                                if (i_class.is_digit) begin
                                    n_acc = LEN_BITS'(i_class.digit);
                                    n_ds  = 1'b1;
                                end else begin
                                    n_inv = 1'b1;
                                end
                            end
                        end else begin
                            n_phase = PH_INLINE;
                        end
                    end
                end
                PH_DISCARD: begin
                    if (lf_after_cr) begin
                        n_acr   = 1'b0;
                        n_phase = PH_IDLE;
                    end else begin
                        n_acr = i_class.is_cr;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_acr        <= 1'b0;
            r_inv        <= 1'b0;
            r_ds         <= 1'b0;
            r_acc        <= '0;
            r_args_left  <= '0;
            r_args_total <= '0;
            r_pay_left   <= '0;
            r_rb         <= '0;
        end else begin
            r_phase      <= n_phase;
            r_acr        <= n_acr;
            r_inv        <= n_inv;
            r_ds         <= n_ds;
            r_acc        <= n_acc;
            r_args_left  <= n_args_left;
            r_args_total <= n_args_total;
            r_pay_left   <= n_pay_left;
            r_rb         <= n_rb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    `RRF_ASSERT_IMPLY(a_push_needs_take, o_res_push, o_take)
    `RRF_ASSERT_IMPLY(a_error_zero_fields,
        o_res_push && o_result.status != rrf_pkg::ST_ARRAY_DONE &&
        o_result.status != rrf_pkg::ST_INLINE_DONE,
        o_result.request_length == '0 && o_result.arg_count == '0)
    `RRF_ASSERT(a_payload_nonzero, r_phase != PH_PAYLOAD || r_pay_left != '0)
    `RRF_ASSERT_NEXT(a_bad_term_restart,
        o_res_push && o_result.status == rrf_pkg::ST_BAD_TERM,
        (r_phase == PH_COUNT || r_phase == PH_INLINE) && r_rb == 32'd2)

endmodule

`default_nettype wire

### dv/tb_resp_request_framer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Request framer testbench
// Feeds RESP request byte streams into the framer, predicts each result word
// with a local parser model and compares results in order as they are popped.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_resp_request_framer_top;

    typedef enum logic [8:0] {
        P_IDLE    = 9'b000000001,
        P_INLINE  = 9'b000000010,
        P_COUNT   = 9'b000000100,
        P_ARG     = 9'b000001000,
        P_LEN     = 9'b000010000,
        P_PAYLOAD = 9'b000100000,
        P_TERM1   = 9'b001000000,
        P_TERM2   = 9'b010000000,
        P_DISCARD = 9'b100000000
    } t_phase;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        pop = 1'b0;
    wire         full;
    wire         empty;
    wire [2:0]   o_status;
    wire [31:0]  o_request_length;
    wire [31:0]  o_arg_count;

    resp_request_framer_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_data_byte(i_data_byte),
        .pop(pop), .empty(empty),
        .o_status(o_status), .o_request_length(o_request_length),
        .o_arg_count(o_arg_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Parser model state.
    t_phase      ph;
    logic        cr_seen, bad_line, have_digit;
    logic [31:0] acc, args_left, args_total, pay_left, req_bytes;
    logic [7:0]  held;

    rrf_pkg::t_result expected_q[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          recv_hold = 1'b0;
    int          quiet_cycles = 0;
    int          bytes_sent = 0;

    function automatic void count_byte();
        if (req_bytes != 32'hFFFF_FFFF) req_bytes = req_bytes + 1;
    endfunction

    function automatic void line_start();
        cr_seen = 0; bad_line = 0; have_digit = 0; acc = 0;
    endfunction

    function automatic void add_digit(logic [7:0] b);
        logic [31:0] d;
        if (b < rrf_pkg::CH_ZERO || b > rrf_pkg::CH_NINE) begin
            bad_line = 1;
            return;
        end
        d = 32'(b - rrf_pkg::CH_ZERO);
        if (acc > (32'hFFFF_FFFF - d) / 10) begin
            bad_line = 1;
            return;
        end
        acc = acc * 10 + d;
        have_digit = 1;
    endfunction

    // Returns 1 at the LF that ends a line.
    function automatic bit line_feed(logic [7:0] b);
        if (cr_seen) begin
            if (b == rrf_pkg::CH_LF) begin
                cr_seen = 0;
                return 1;
            end
            bad_line = 1;
        end
        if (b == rrf_pkg::CH_CR) begin
            cr_seen = 1;
            return 0;
        end
        cr_seen = 0;
        add_digit(b);
        return 0;
    endfunction

    function automatic bit parse_byte(logic [7:0] b, output rrf_pkg::t_result r);
        rrf_pkg::t_result dummy;
        bit               unused;
        r = '0;
        case (ph)
            P_INLINE: begin
                count_byte();
                if (line_feed(b)) begin
                    ph = P_IDLE;
                    r.status = rrf_pkg::ST_INLINE_DONE; r.request_length = req_bytes;
                    return 1;
                end
                return 0;
            end
            P_COUNT: begin
                count_byte();
                if (!line_feed(b)) return 0;
                ph = P_IDLE;
                if (!(have_digit && !bad_line)) begin
                    r.status = rrf_pkg::ST_BAD_COUNT;
                    return 1;
                end
                if (acc == 0) begin
                    r.status = rrf_pkg::ST_ARRAY_DONE; r.request_length = req_bytes;
                    return 1;
                end
                args_left = acc; args_total = acc; ph = P_ARG;
                return 0;
            end
            P_ARG: begin
                count_byte();
                line_start();
                if (b == rrf_pkg::CH_DOLLAR) begin
                    ph = P_LEN;
                    return 0;
                end
                unused = line_feed(b);
                ph = P_DISCARD;
                r.status = rrf_pkg::ST_NO_DOLLAR;
                return 1;
            end
            P_LEN: begin
                count_byte();
                if (!line_feed(b)) return 0;
                if (!(have_digit && !bad_line)) begin
                    ph = P_IDLE;
                    r.status = rrf_pkg::ST_BAD_LENGTH;
                    return 1;
                end
                pay_left = acc;
                ph = (pay_left != 0) ? P_PAYLOAD : P_TERM1;
                return 0;
            end
            P_PAYLOAD: begin
                count_byte();
                if (pay_left != 0) pay_left = pay_left - 1;
                if (pay_left == 0) ph = P_TERM1;
                return 0;
            end
            P_TERM1: begin
                count_byte();
                held = b; ph = P_TERM2;
                return 0;
            end
            P_TERM2: begin
                if (held == rrf_pkg::CH_CR && b == rrf_pkg::CH_LF) begin
                    count_byte();
                    if (args_left != 0) args_left = args_left - 1;
                    if (args_left == 0) begin
                        ph = P_IDLE;
                        r.status = rrf_pkg::ST_ARRAY_DONE; r.request_length = req_bytes;
                        r.arg_count = args_total;
                        return 1;
                    end
                    ph = P_ARG;
                    return 0;
                end
                ph = P_IDLE;
                unused = parse_byte(held, dummy);
                unused = parse_byte(b, dummy);
                r.status = rrf_pkg::ST_BAD_TERM;
                return 1;
            end
            P_DISCARD: begin
                if (line_feed(b)) ph = P_IDLE;
                return 0;
            end
            default: begin
                req_bytes = 1;
                line_start();
                if (b == rrf_pkg::CH_STAR) ph = P_COUNT;
                else begin
                    ph = P_INLINE;
                    unused = line_feed(b);
                end
                return 0;
            end
        endcase
    endfunction

    task automatic send_byte(logic [7:0] b);
        rrf_pkg::t_result r;
        // Push stays high from the last byte unless the sender idles here.
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
        if (parse_byte(b, r)) expected_q.insert(expected_q.size(), r);
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    task automatic idle_sender();
        push <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        idle_sender();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: status %0d len %0d args %0d",
                                 o_status, o_request_length, o_arg_count);
                end else begin
                    rrf_pkg::t_result e;
                    e = expected_q.pop_front();
                    if (o_status !== e.status || o_request_length !== e.request_length ||
                        o_arg_count !== e.arg_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     e.status, e.request_length, e.arg_count,
                                     o_status, o_request_length, o_arg_count);
                    end
                end
            end
            pop <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic string num_text(int unsigned v);
        return $sformatf("%0d", v);
    endfunction

    task automatic send_array_request(int nargs, int maxlen, bit corrupt);
        int len;
        int kind;
        send_text({"*", num_text(nargs), "\015\n"});
        for (int a = 0; a < nargs; a++) begin
            len = $urandom_range(maxlen);
            kind = corrupt ? $urandom_range(5) : 0;
            if (kind == 1) send_byte(8'($urandom_range(255)));
            else send_byte(rrf_pkg::CH_DOLLAR);
            if (kind == 2) send_text({num_text(len), "x\015\n"});
            else send_text({num_text(len), "\015\n"});
            for (int p = 0; p < len; p++) send_byte(8'($urandom_range(255)));
            if (kind == 3) begin
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(255)));
            end else send_text("\015\n");
            if (kind != 0) return;
        end
    endtask

    task automatic test_directed();
        send_text("*0\015\n");
        send_text("PING\015\n");
        send_text("\015\n");
        send_text("*2\015\n$3\015\nGET\015\n$0\015\n\015\n");
        send_text("*1\015\n$2\015\n\015\n\015\n");
        send_text("*x\015\n");
        send_text("*\015\n");
        send_text("*4294967296\015\n");
        send_text("*1\015\n#abc\015\n");
        send_text("*1\015\n$\015\n");
        send_text("*1\015\n$4294967295x\015\n");
        send_text("*1\015\n$1\015\nAxy");
        send_text("\015\n");
        send_text("*1\015\n$1\015\nA\015*1\015\n$1\015\n");
        send_byte(8'hFF);
        send_text("\015\n");
        send_text("a\015b\015\n");
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text("\015\n");
        drain();
    endtask

    task automatic test_random(int n_items, int s_pct, int r_pct);
        int start;
        start = bytes_sent;
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        while (bytes_sent - start < n_items) begin
            case ($urandom_range(9))
                0: send_text({"ab", num_text($urandom_range(99)), "\015\n"});
                1: send_byte(8'($urandom_range(255)));
                2: send_array_request($urandom_range(3), 6, 1'b1);
                default: send_array_request($urandom_range(4), 6, 1'b0);
            endcase
        end
        drain();
    endtask

    task automatic test_backpressure();
        int hold;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold = 200;
        recv_hold = 1'b1;
        fork
            begin
                repeat (hold) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            begin
                for (int k = 0; k < 8; k++) send_text("OK\015\n");
            end
        join
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        ph = P_IDLE; cr_seen = 0; bad_line = 0; have_digit = 0; acc = 0;
        args_left = 0; args_total = 0; pay_left = 0; req_bytes = 0; held = 0;
        @(posedge i_clk);
        test_directed();
        test_random(300, 0, 0);
        test_random(280, 56, 0);
        test_random(280, 0, 56);
        test_random(290, 23, 23);
        test_backpressure();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/rrf_pkg.sv
sv/rrf_fifo.sv
sv/rrf_classify.sv
sv/rrf_parser.sv
sv/resp_request_framer_top.sv
dv/tb_resp_request_framer_top.sv
